// ===== hw/rtl/scar_pkg.sv =====
// Shared types, constants and tuning tables of the stereo comb/allpass reverb.
package scar_pkg;

    // sample formats
    localparam int SAMPLE_W   = 16;
    localparam int INNER_W    = 24;
    localparam int FRAC_W     = INNER_W - 2;
    localparam int COEF_W     = 17;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int DEF_MAX_LINE      = 2048;
    localparam int DEF_COMB_COUNT    = 8;
    localparam int DEF_ALLPASS_COUNT = 4;
    localparam int DEF_STEREO_SPREAD = 23;

    // tuning lengths
    localparam int COMB_TUNE [8]    = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    localparam int ALLPASS_TUNE [4] = '{556, 441, 341, 225};

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ROOM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_ROOM  = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] RST_DAMP  = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] RST_WET   = 16'd9830;
    localparam logic [CFG_DATA_W-1:0] RST_DRY   = 16'd22938;
    localparam logic [CFG_DATA_W-1:0] RST_WIDTH = 16'd32768;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD,
        OP_FB, OP_D1, OP_W1, OP_W2, OP_W2S,
        OP_CB_RD, OP_CB_M1, OP_CB_M2, OP_CB_LP, OP_CB_M3, OP_CB_WR,
        OP_AP_INIT, OP_AP_RD, OP_AP_WR,
        OP_MX_M1, OP_MX_M2, OP_MX_M3, OP_MX_M4, OP_MX_M5, OP_MX_M6,
        OP_EMIT
    } t_op;

    // controller states
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_FB, S_D1, S_W1, S_W2, S_W2S,
        S_CB_RD, S_CB_M1, S_CB_M2, S_CB_LP, S_CB_M3, S_CB_WR,
        S_AP_INIT, S_AP_RD, S_AP_WR,
        S_MX_M1, S_MX_M2, S_MX_M3, S_MX_M4, S_MX_M5, S_MX_M6,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op              op;
        logic             ch;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_status;

    // delay length limited to the line size
    function automatic int clip_len(input int n, input int max_line);
        int r;
        r = (n > max_line) ? max_line : n;
        return (r < 1) ? 1 : r;
    endfunction

endpackage

// ===== hw/rtl/scar_ram.sv =====
// Generic simple dual-port RAM with registered read.
module scar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/scar_ctrl.sv =====
// Sequencer: steps the shared datapath through coefficients, combs, allpasses and mix.
module scar_ctrl #(
    parameter int COMB_COUNT    = scar_pkg::DEF_COMB_COUNT,
    parameter int ALLPASS_COUNT = scar_pkg::DEF_ALLPASS_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output scar_pkg::t_cmd    o_cmd,
    input  scar_pkg::t_status i_status
);
    import scar_pkg::*;

    localparam logic [IDX_W-1:0] LAST_C = IDX_W'(COMB_COUNT - 1);
    localparam logic [IDX_W-1:0] LAST_A = IDX_W'(ALLPASS_COUNT - 1);

    t_state           r_state, n_state;
    logic             r_ch, n_ch;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ch    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_idx   <= n_idx;
        end
    end

    // next state and command
    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_idx      = r_idx;
        o_ready    = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.ch   = r_ch;
        o_cmd.idx  = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_FB;
                end
            end
            S_FB:  begin o_cmd.op = OP_FB;  n_state = S_D1; end
            S_D1:  begin o_cmd.op = OP_D1;  n_state = S_W1; end
            S_W1:  begin o_cmd.op = OP_W1;  n_state = S_W2; end
            S_W2:  begin o_cmd.op = OP_W2;  n_state = S_W2S; end
            S_W2S: begin
                o_cmd.op = OP_W2S;
                n_state  = S_CB_RD;
                n_ch     = 1'b0;
                n_idx    = '0;
            end
            S_CB_RD: begin o_cmd.op = OP_CB_RD; n_state = S_CB_M1; end
            S_CB_M1: begin o_cmd.op = OP_CB_M1; n_state = S_CB_M2; end
            S_CB_M2: begin o_cmd.op = OP_CB_M2; n_state = S_CB_LP; end
            S_CB_LP: begin o_cmd.op = OP_CB_LP; n_state = S_CB_M3; end
            S_CB_M3: begin o_cmd.op = OP_CB_M3; n_state = S_CB_WR; end
            S_CB_WR: begin
                o_cmd.op = OP_CB_WR;
                n_state  = S_CB_RD;
                if (r_idx == LAST_C) begin
                    n_idx = '0;
                    if (r_ch) n_state = S_AP_INIT;
                    else n_ch = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_AP_INIT: begin
                o_cmd.op = OP_AP_INIT;
                n_state  = S_AP_RD;
                n_ch     = 1'b0;
                n_idx    = '0;
            end
            S_AP_RD: begin o_cmd.op = OP_AP_RD; n_state = S_AP_WR; end
            S_AP_WR: begin
                o_cmd.op = OP_AP_WR;
                n_state  = S_AP_RD;
                if (r_idx == LAST_A) begin
                    n_idx = '0;
                    if (r_ch) begin
                        n_state = S_MX_M1;
                        n_ch    = 1'b0;
                    end else begin
                        n_ch = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MX_M1: begin o_cmd.op = OP_MX_M1; n_state = S_MX_M2; end
            S_MX_M2: begin o_cmd.op = OP_MX_M2; n_state = S_MX_M3; end
            S_MX_M3: begin o_cmd.op = OP_MX_M3; n_state = S_MX_M4; end
            S_MX_M4: begin o_cmd.op = OP_MX_M4; n_state = S_MX_M5; end
            S_MX_M5: begin o_cmd.op = OP_MX_M5; n_state = S_MX_M6; end
            S_MX_M6: begin
                o_cmd.op = OP_MX_M6;
                if (r_ch) begin
                    n_state = S_DONE;
                end else begin
                    n_ch    = 1'b1;
                    n_state = S_MX_M1;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

// ===== hw/rtl/scar_dp.sv =====
// Datapath: settings, shared multiplier, delay-line memories and output register.
module scar_dp #(
    parameter int MAX_LINE      = scar_pkg::DEF_MAX_LINE,
    parameter int COMB_COUNT    = scar_pkg::DEF_COMB_COUNT,
    parameter int ALLPASS_COUNT = scar_pkg::DEF_ALLPASS_COUNT,
    parameter int STEREO_SPREAD = scar_pkg::DEF_STEREO_SPREAD
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  scar_pkg::t_cmd                        i_cmd,
    output scar_pkg::t_status                     o_status,
    input  logic                                  i_cfg_we,
    input  logic [scar_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [scar_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [scar_pkg::SAMPLE_W-1:0]  i_left,
    input  logic signed [scar_pkg::SAMPLE_W-1:0]  i_right,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [scar_pkg::SAMPLE_W-1:0]  o_left,
    output logic signed [scar_pkg::SAMPLE_W-1:0]  o_right,
    output logic                                  o_last
);
    import scar_pkg::*;

    localparam int LW    = $clog2(MAX_LINE);
    localparam int CW    = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
    localparam int APW   = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
    localparam int CAW   = 1 + CW + LW;
    localparam int APAW  = 1 + APW + LW;
    localparam int MW    = (CAW > APAW) ? CAW : APAW;
    localparam int NCK   = 2 ** (1 + CW);
    localparam int NAK   = 2 ** (1 + APW);
    localparam int PW    = 44;
    localparam int TW    = 46;
    localparam int SUMW  = INNER_W + 5;
    localparam int MAW   = 25;
    localparam int MBW   = 19;
    localparam int IN_SH = FRAC_W - 15;

    localparam logic signed [TW-1:0] SAT_HI = TW'(2 ** (INNER_W - 1) - 1);
    localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [TW-1:0] ONE    = TW'(2 ** FRAC_W);
    localparam logic signed [TW-1:0] FB_BASE = TW'(22938);
    localparam logic [COEF_W-1:0]    UNITY   = 17'd32768;

    // saturate to the inner sample width
    function automatic logic signed [INNER_W-1:0] sat_in(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] r;
        r = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return r[INNER_W-1:0];
    endfunction

    // shift right by s, rounding half up
    function automatic logic signed [TW-1:0] shr_rnd(input logic signed [TW-1:0] v,
                                                    input int s);
        logic signed [TW-1:0] half;
        half = $signed(TW'(1) << (s - 1));
        return (v + half) >>> s;
    endfunction

    function automatic logic [COEF_W-1:0] lim(input logic [CFG_DATA_W-1:0] v);
        return (v > 16'd32768) ? UNITY : COEF_W'(v);
    endfunction

    // settings
    logic [CFG_DATA_W-1:0] r_room, r_damp, r_wet, r_dry, r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room  <= RST_ROOM;
            r_damp  <= RST_DAMP;
            r_wet   <= RST_WET;
            r_dry   <= RST_DRY;
            r_width <= RST_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROOM:  r_room  <= i_cfg_data;
                REG_DAMP:  r_damp  <= i_cfg_data;
                REG_WET:   r_wet   <= i_cfg_data;
                REG_DRY:   r_dry   <= i_cfg_data;
                REG_WIDTH: r_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [COEF_W-1:0] w_room, w_damp, w_wet, w_dry, w_width, w_d2;
    assign w_room  = lim(r_room);
    assign w_damp  = lim(r_damp);
    assign w_wet   = lim(r_wet);
    assign w_dry   = lim(r_dry);
    assign w_width = lim(r_width);

    // delay lengths per section
    logic [LW:0] w_clen [NCK];
    logic [LW:0] w_alen [NAK];
    for (genvar k = 0; k < NCK; k++) begin : g_clen
        localparam int CH = k / (2 ** CW);
        localparam int CI = k % (2 ** CW);
        assign w_clen[k] = (LW + 1)'(clip_len(COMB_TUNE[CI % 8] + CH * STEREO_SPREAD,
                                              MAX_LINE));
    end
    for (genvar k = 0; k < NAK; k++) begin : g_alen
        localparam int CH = k / (2 ** APW);
        localparam int AI = k % (2 ** APW);
        assign w_alen[k] = (LW + 1)'(clip_len(ALLPASS_TUNE[AI % 4] + CH * STEREO_SPREAD,
                                              MAX_LINE));
    end

    // frame state
    logic signed [INNER_W-1:0]  r_in_l, r_in_r, r_mono, r_held, r_clamp;
    logic signed [INNER_W-1:0]  r_w [2];
    logic signed [SUMW-1:0]     r_sum [2];
    logic signed [SAMPLE_W-1:0] r_res [2];
    logic                       r_flast;
    logic [COEF_W-1:0]          r_fb, r_d1, r_w1, r_w2;
    logic signed [PW-1:0]       r_prod;
    logic signed [TW-1:0]       r_tmp;
    logic signed [INNER_W-1:0]  r_lp [NCK];
    logic [LW-1:0]              r_cpos [NCK];
    logic [LW-1:0]              r_apos [NAK];
    logic [MW-1:0]              r_clr;
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_oleft, r_oright;
    logic                       r_olast;

    assign w_d2 = UNITY - r_d1;

    logic [CW:0]  w_ck;
    logic [APW:0] w_ak;
    assign w_ck = {i_cmd.ch, i_cmd.idx[CW-1:0]};
    assign w_ak = {i_cmd.ch, i_cmd.idx[APW-1:0]};

    // shared multiplier
    logic signed [MAW-1:0] w_ma;
    logic signed [MBW-1:0] w_mb;
    logic signed [PW-1:0]  w_prod;
    logic [INNER_W-1:0]    w_crd, w_ard;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            OP_FB:    begin w_ma = $signed(MAW'(w_room)); w_mb = MBW'(9175);  end
            OP_D1:    begin w_ma = $signed(MAW'(w_damp)); w_mb = MBW'(13107); end
            OP_W1: begin
                w_ma = $signed(MAW'(w_wet));
                w_mb = $signed(MBW'(w_width) + MBW'(32768));
            end
            OP_W2: begin
                w_ma = $signed(MAW'(w_wet));
                w_mb = $signed(MBW'(32768) - MBW'(w_width));
            end
            OP_CB_M1: begin w_ma = MAW'($signed(w_crd)); w_mb = $signed(MBW'(w_d2)); end
            OP_CB_M2: begin w_ma = MAW'(r_lp[w_ck]); w_mb = $signed(MBW'(r_d1)); end
            OP_CB_M3: begin w_ma = MAW'(r_lp[w_ck]); w_mb = $signed(MBW'(r_fb)); end
            OP_MX_M1: begin
                w_ma = MAW'(i_cmd.ch ? r_w[1] : r_w[0]);
                w_mb = $signed(MBW'(r_w1));
            end
            OP_MX_M2: begin
                w_ma = MAW'(i_cmd.ch ? r_w[0] : r_w[1]);
                w_mb = $signed(MBW'(r_w2));
            end
            OP_MX_M3: begin
                w_ma = MAW'(i_cmd.ch ? r_in_r : r_in_l);
                w_mb = $signed(MBW'(w_dry));
            end
            OP_MX_M5: begin w_ma = MAW'(r_clamp); w_mb = MBW'(32767); end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // derived values of the current step
    logic signed [TW-1:0]      w_ptw, w_mix;
    logic signed [INNER_W-1:0] w_cb_wval, w_lp_new, w_ap_out, w_ap_wval, w_wcur, w_ap_held;
    logic [LW:0]               w_cnext, w_anext;
    logic signed [PW-1:0]      w_bias, w_tsum;

    assign w_ptw     = TW'(r_prod);
    assign w_cb_wval = sat_in(TW'(r_mono) + shr_rnd(w_ptw, 15));
    assign w_lp_new  = sat_in(shr_rnd(r_tmp + w_ptw, 15));
    assign w_mix     = shr_rnd(r_tmp + w_ptw, 15);
    assign w_wcur    = i_cmd.ch ? r_w[1] : r_w[0];
    assign w_ap_held = $signed(w_ard);
    assign w_ap_out  = sat_in(TW'(w_ap_held) - TW'(w_wcur));
    assign w_ap_wval = sat_in(TW'(w_wcur) + shr_rnd(TW'(w_ap_held), 1));
    assign w_cnext   = (LW + 1)'(r_cpos[w_ck]) + 1'b1;
    assign w_anext   = (LW + 1)'(r_apos[w_ak]) + 1'b1;
    assign w_bias    = r_prod[PW-1] ? $signed(PW'(2 ** FRAC_W - 1)) : $signed(PW'(0));
    assign w_tsum    = r_prod + w_bias;

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NCK; k++) begin
                r_cpos[k] <= '0;
                r_lp[k]   <= '0;
            end
            for (int k = 0; k < NAK; k++) begin
                r_apos[k] <= '0;
            end
        end else begin
            if (i_cmd.op == OP_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cmd.op == OP_EMIT) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (i_cmd.op == OP_CB_LP) r_lp[w_ck] <= w_lp_new;
            if (i_cmd.op == OP_CB_WR) begin
                r_cpos[w_ck] <= (w_cnext >= w_clen[w_ck]) ? '0 : w_cnext[LW-1:0];
            end
            if (i_cmd.op == OP_AP_WR) begin
                r_apos[w_ak] <= (w_anext >= w_alen[w_ak]) ? '0 : w_anext[LW-1:0];
            end
        end
    end

    // sample and coefficient registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_in_l   <= INNER_W'(i_left) <<< IN_SH;
                r_in_r   <= INNER_W'(i_right) <<< IN_SH;
                r_mono   <= INNER_W'(shr_rnd((TW'(i_left) + TW'(i_right)) <<< IN_SH, 1));
                r_flast  <= i_last;
                r_sum[0] <= '0;
                r_sum[1] <= '0;
            end
            OP_D1:    r_fb <= COEF_W'(FB_BASE + shr_rnd(w_ptw, 15));
            OP_W1:    r_d1 <= COEF_W'(shr_rnd(w_ptw, 15));
            OP_W2:    r_w1 <= COEF_W'(shr_rnd(w_ptw, 16));
            OP_W2S:   r_w2 <= COEF_W'(shr_rnd(w_ptw, 16));
            OP_CB_M1: r_held <= $signed(w_crd);
            OP_CB_M2: r_tmp <= w_ptw;
            OP_CB_WR: r_sum[i_cmd.ch] <= r_sum[i_cmd.ch] + SUMW'(r_held);
            OP_AP_INIT: begin
                r_w[0] <= sat_in(shr_rnd(TW'(r_sum[0]), 3));
                r_w[1] <= sat_in(shr_rnd(TW'(r_sum[1]), 3));
            end
            OP_AP_WR: r_w[i_cmd.ch] <= w_ap_out;
            OP_MX_M2: r_tmp <= w_ptw;
            OP_MX_M3: r_tmp <= r_tmp + w_ptw;
            OP_MX_M4: begin
                r_clamp <= INNER_W'((w_mix > ONE) ? ONE : ((w_mix < -ONE) ? -ONE : w_mix));
            end
            OP_MX_M6: r_res[i_cmd.ch] <= SAMPLE_W'(w_tsum >>> FRAC_W);
            OP_EMIT: begin
                r_oleft  <= r_res[0];
                r_oright <= r_res[1];
                r_olast  <= r_flast;
            end
            default: ;
        endcase
    end

    // delay-line memories
    logic            w_cwe, w_awe;
    logic [CAW-1:0]  w_caddr;
    logic [APAW-1:0] w_aaddr;
    logic [INNER_W-1:0] w_cwdata, w_awdata;

    assign w_cwe    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_CB_WR);
    assign w_awe    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_AP_WR);
    assign w_caddr  = (i_cmd.op == OP_CLEAR) ? r_clr[CAW-1:0]
                                             : {w_ck, r_cpos[w_ck]};
    assign w_aaddr  = (i_cmd.op == OP_CLEAR) ? r_clr[APAW-1:0]
                                             : {w_ak, r_apos[w_ak]};
    assign w_cwdata = (i_cmd.op == OP_CLEAR) ? '0 : w_cb_wval;
    assign w_awdata = (i_cmd.op == OP_CLEAR) ? '0 : w_ap_wval;

    scar_ram #(.WIDTH(INNER_W), .DEPTH(2 ** CAW)) u_comb_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_caddr),
        .i_wdata (w_cwdata),
        .i_raddr (w_caddr),
        .o_rdata (w_crd)
    );

    scar_ram #(.WIDTH(INNER_W), .DEPTH(2 ** APAW)) u_ap_ram (
        .i_clk   (i_clk),
        .i_we    (w_awe),
        .i_waddr (w_aaddr),
        .i_wdata (w_awdata),
        .i_raddr (w_aaddr),
        .o_rdata (w_ard)
    );

    assign o_status.clr_last = &r_clr;
    assign o_status.out_busy = r_ovalid && !i_ready;
    assign o_valid = r_ovalid;
    assign o_left  = r_oleft;
    assign o_right = r_oright;
    assign o_last  = r_olast;
endmodule

// ===== hw/rtl/stereo_comb_allpass_reverb_core.sv =====
// One frame is taken at a time: a new input word is accepted only after the output word of
// the previous frame has been emitted, as all steps are sequenced over the
// single shared multiplier and one read per delay-line memory per section.
// Reset (synchronous, active low) restores the settings, then a clearing pass zeroes the
// delay lines with tready low; configuration writes are taken during it.
module stereo_comb_allpass_reverb_core #(
    parameter int MAX_LINE      = scar_pkg::DEF_MAX_LINE,
    parameter int COMB_COUNT    = scar_pkg::DEF_COMB_COUNT,
    parameter int ALLPASS_COUNT = scar_pkg::DEF_ALLPASS_COUNT,
    parameter int STEREO_SPREAD = scar_pkg::DEF_STEREO_SPREAD
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // left_in, right_in
    input  logic                              s_axis_tlast,  // frame_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // left_out, right_out
    output logic                              m_axis_tlast,  // out_last
    input  logic                              i_cfg_we,
    input  logic [scar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scar_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import scar_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic signed [SAMPLE_W-1:0] w_oleft, w_oright;

    scar_ctrl #(
        .COMB_COUNT    (COMB_COUNT),
        .ALLPASS_COUNT (ALLPASS_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    scar_dp #(
        .MAX_LINE      (MAX_LINE),
        .COMB_COUNT    (COMB_COUNT),
        .ALLPASS_COUNT (ALLPASS_COUNT),
        .STEREO_SPREAD (STEREO_SPREAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_left      ($signed(s_axis_tdata[15:0])),
        .i_right     ($signed(s_axis_tdata[31:16])),
        .i_last      (s_axis_tlast),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_left      (w_oleft),
        .o_right     (w_oright),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {w_oright, w_oleft};
endmodule
